// ----- src/assert_macros.svh -----
// Assertion macros shared by the line discipline RTL.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TLD_ASSERT(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define TLD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/tld_pkg.sv -----
// Package for the telnet line discipline: byte codes, result kinds and
// the control struct that drives the line store cells. No dependencies.
`default_nettype none

package tld_pkg;

	// Telnet and ASCII byte codes.
	localparam logic [7:0] BYTE_IAC      = 8'd255;
	localparam logic [7:0] BYTE_WILL     = 8'd251;
	localparam logic [7:0] BYTE_DO       = 8'd253;
	localparam logic [7:0] BYTE_DONT     = 8'd254;
	localparam logic [7:0] BYTE_OPT_ECHO = 8'd1;
	localparam logic [7:0] BYTE_CR       = 8'd13;
	localparam logic [7:0] BYTE_LF       = 8'd10;
	localparam logic [7:0] BYTE_BS       = 8'd8;
	localparam logic [7:0] BYTE_DEL      = 8'd127;
	localparam logic [7:0] BYTE_SPACE    = 8'd32;
	localparam logic [7:0] BYTE_PRINT_HI = 8'd126;

	// Kinds of result item.
	localparam logic [1:0] KIND_ECHO = 2'd0;
	localparam logic [1:0] KIND_CHAR = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	// Parser modes.
	localparam logic [1:0] MODE_TEXT = 2'd0;
	localparam logic [1:0] MODE_CMD  = 2'd1;
	localparam logic [1:0] MODE_OPT  = 2'd2;

	// Control common to every cell of the line store.
	typedef struct packed {
		logic shift;  // every cell takes its right neighbor's character
		logic load;   // the selected cell takes the incoming character
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- src/telnet_line_discipline_core.sv -----
// Top level of the telnet line discipline: parser, result sequencer and
// the chain of tld_cell character cells. Depends on tld_pkg, tld_cell
// and assert_macros.svh.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   input    | in_valid, in_ready, rx_byte               | in
//   result   | out_valid, out_ready, out_kind, out_byte, | out
//            | run_last, line_truncated                  |
//
// A byte with at most one result is accepted in the cycle that emits it,
// so text flows at one item per cycle while the result side keeps up. A
// byte with more results holds the input until the last one is emitted,
// one per cycle while the output keeps up; a carriage return gives CR and
// LF with echo, each stored character as the cells shift, and the end.
// A stall on the result side freezes the sequencer; the output register
// still lets the next byte in once the pending result is taken.
// Reset clears the parser, the echo flag, the line length, the overflow
// flag and the sequencer; the character cells are not reset.
`default_nettype none
`include "assert_macros.svh"

module telnet_line_discipline_core #(
	parameter int LINE_DEPTH = 32
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [7:0] rx_byte,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [1:0] out_kind,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       line_truncated
);
	import tld_pkg::*;

	localparam int LEN_W = $clog2(LINE_DEPTH + 1);

	// Sequencer states; each state other than idle emits one result.
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ECHO  = 4'd1;
	localparam logic [3:0] S_ERA1  = 4'd2;
	localparam logic [3:0] S_ERA2  = 4'd3;
	localparam logic [3:0] S_ERA3  = 4'd4;
	localparam logic [3:0] S_CR    = 4'd5;
	localparam logic [3:0] S_LF    = 4'd6;
	localparam logic [3:0] S_DRAIN = 4'd7;
	localparam logic [3:0] S_END   = 4'd8;

	logic [1:0]       mode_q;
	logic [7:0]       pend_q;
	logic             echo_q;
	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic [3:0]       state_q;
	logic [7:0]       byte_q;

	logic             ov_q;
	logic [1:0]       kind_q;
	logic [7:0]       obyte_q;
	logic             last_q;
	logic             trunc_q;

	logic             slot_free;
	logic             accept;
	logic             in_text;
	logic             is_print;
	logic             is_erase;
	logic             has_room;
	logic             not_empty;
	logic [3:0]       start_state;
	logic [3:0]       eff_state;
	logic [7:0]       eff_byte;
	logic             emit;
	logic [3:0]       nxt_state;
	logic [1:0]       e_kind;
	logic [7:0]       e_byte;
	logic             e_last;
	logic             e_trunc;
	cell_ctl_t        cell_ctl;
	logic [7:0]       cell_data [LINE_DEPTH+1];

	// The output register frees its slot when empty or when being taken.
	assign slot_free = !ov_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;

	// Mode 3 never arises and counts as text.
	assign in_text   = (mode_q != MODE_CMD) && (mode_q != MODE_OPT);
	assign is_print  = (rx_byte >= BYTE_SPACE) && (rx_byte <= BYTE_PRINT_HI);
	assign is_erase  = (rx_byte == BYTE_BS) || (rx_byte == BYTE_DEL);
	assign has_room  = len_q < LEN_W'(LINE_DEPTH);
	assign not_empty = len_q != '0;

	// First result of a newly accepted byte, chosen from the byte itself.
	always_comb begin
		start_state = S_IDLE;
		if (in_text) begin
			if (rx_byte == BYTE_CR) begin
				if (echo_q) begin
					start_state = S_CR;
				end else if (not_empty) begin
					start_state = S_DRAIN;
				end else begin
					start_state = S_END;
				end
			end else if (is_erase) begin
				if (not_empty && echo_q) begin
					start_state = S_ERA1;
				end
			end else if (is_print) begin
				if (has_room && echo_q) begin
					start_state = S_ECHO;
				end
			end
		end
	end

	// The first result is registered in the cycle the byte is accepted.
	assign eff_state = accept ? start_state : state_q;
	assign eff_byte  = accept ? rx_byte : byte_q;
	assign emit      = slot_free && (eff_state != S_IDLE);

	always_comb begin
		e_kind    = KIND_ECHO;
		e_byte    = eff_byte;
		e_last    = 1'b0;
		e_trunc   = 1'b0;
		nxt_state = S_IDLE;
		case (eff_state)
			S_ECHO: begin
				e_last = 1'b1;
			end
			S_ERA1: begin
				nxt_state = S_ERA2;
			end
			S_ERA2: begin
				e_byte    = BYTE_SPACE;
				nxt_state = S_ERA3;
			end
			S_ERA3: begin
				e_last = 1'b1;
			end
			S_CR: begin
				e_byte    = BYTE_CR;
				nxt_state = S_LF;
			end
			S_LF: begin
				e_byte    = BYTE_LF;
				nxt_state = not_empty ? S_DRAIN : S_END;
			end
			S_DRAIN: begin
				// The head cell always holds the next stored character.
				e_kind    = KIND_CHAR;
				e_byte    = cell_data[0];
				nxt_state = (len_q == LEN_W'(1)) ? S_END : S_DRAIN;
			end
			S_END: begin
				e_kind  = KIND_END;
				e_byte  = 8'd0;
				e_trunc = ovf_q;
				e_last  = 1'b1;
			end
			default: begin
				nxt_state = S_IDLE;
			end
		endcase
	end

	// Parser and line bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_TEXT;
			pend_q  <= 8'd0;
			echo_q  <= 1'b0;
			len_q   <= '0;
			ovf_q   <= 1'b0;
			state_q <= S_IDLE;
		end else begin
			if (emit) begin
				state_q <= nxt_state;
			end
			if (accept) begin
				if (mode_q == MODE_CMD) begin
					pend_q <= rx_byte;
					mode_q <= (rx_byte >= BYTE_WILL && rx_byte <= BYTE_DONT) ? MODE_OPT
						: MODE_TEXT;
				end else if (mode_q == MODE_OPT) begin
					if (rx_byte == BYTE_OPT_ECHO) begin
						if (pend_q == BYTE_DO) begin
							echo_q <= 1'b1;
						end else if (pend_q == BYTE_DONT) begin
							echo_q <= 1'b0;
						end
					end
					mode_q <= MODE_TEXT;
				end else begin
					mode_q <= (rx_byte == BYTE_IAC) ? MODE_CMD : MODE_TEXT;
					if (is_print) begin
						if (has_room) begin
							len_q <= len_q + LEN_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end else if (is_erase && not_empty) begin
						len_q <= len_q - LEN_W'(1);
					end
				end
			end
			// Draining shortens the line one character per result; a
			// carriage return changes nothing else on acceptance.
			if (emit && eff_state == S_DRAIN) begin
				len_q <= len_q - LEN_W'(1);
			end
			if (emit && eff_state == S_END) begin
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= rx_byte;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= e_kind;
			obyte_q <= e_byte;
			last_q  <= e_last;
			trunc_q <= e_trunc;
		end
	end

	assign out_valid      = ov_q;
	assign out_kind       = kind_q;
	assign out_byte       = obyte_q;
	assign run_last       = last_q;
	assign line_truncated = trunc_q;

	// Line store: a chain of cells. A printable byte lands in the cell at
	// the current length; draining shifts every cell one place toward the
	// head, so the head always presents the oldest character.
	assign cell_ctl.shift = emit && (eff_state == S_DRAIN);
	assign cell_ctl.load  = accept && in_text && is_print && has_room;
	assign cell_data[LINE_DEPTH] = 8'd0;

	for (genvar i = 0; i < LINE_DEPTH; i++) begin : g_cell
		tld_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl),
			.sel        (len_q == LEN_W'(i)),
			.load_data  (rx_byte),
			.right_data (cell_data[i+1]),
			.data       (cell_data[i])
		);
	end

	`TLD_ASSERT(a_len_bound, len_q <= LEN_W'(LINE_DEPTH), "line length beyond store depth")
	`TLD_ASSERT(a_drain_nonempty, (state_q != S_DRAIN) || not_empty, "draining an empty line")
	`TLD_ASSERT_NEXT(a_end_clears, emit && (eff_state == S_END), (len_q == '0) && !ovf_q, "line end did not clear the line")
	`TLD_ASSERT(a_kind_valid, !ov_q || (kind_q == KIND_ECHO) || (kind_q == KIND_CHAR) || (kind_q == KIND_END), "bad result kind")

endmodule

`default_nettype wire

// ----- src/tld_cell.sv -----
// One character cell of the line store chain.
// Depends on tld_pkg for the cell control struct.
`default_nettype none

module tld_cell (
	input  wire               clk,
	input  wire tld_pkg::cell_ctl_t ctl,
	input  wire               sel,
	input  wire  [7:0]        load_data,
	input  wire  [7:0]        right_data,
	output logic [7:0]        data
);
	import tld_pkg::*;

	logic [7:0] char_q;

	// Holds payload only, so there is no reset.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			char_q <= right_data;
		end else if (ctl.load && sel) begin
			char_q <= load_data;
		end
	end

	assign data = char_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for telnet_line_discipline_core: random and directed
// telnet byte streams, a scoreboard class that predicts every result item.
// Depends on tld_pkg and the RTL of telnet_line_discipline_core.
`default_nettype none

module tb;
	import tld_pkg::*;

	localparam int LINE_DEPTH = 32;
	localparam logic [7:0] BYTE_WONT = 8'd252;
	localparam int RANDOM_ITEMS = 420;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_TAIL = 50;
	// Worst case: every item a full line with echo, each result waiting out
	// the longest receiver gap, plus sender gaps and the long hold, then x4.
	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int MAX_PRINTED = 100;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
		logic       trunc;
	} tld_result_t;

	// Scoreboard: tracks the line discipline state and queues the result
	// items that each accepted byte should produce.
	class line_scoreboard;
		logic [1:0]  parse_mode;
		logic [7:0]  pending_cmd;
		logic        echo_on;
		int unsigned line_len;
		logic [7:0]  line_chars [LINE_DEPTH];
		logic        overflow;
		tld_result_t due_results [$];
		tld_result_t run [$];
		int          errors;

		function new();
			parse_mode = MODE_TEXT;
			pending_cmd = 8'd0;
			echo_on = 1'b0;
			line_len = 0;
			overflow = 1'b0;
			errors = 0;
			foreach (line_chars[i])
				line_chars[i] = 8'd0;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void add(logic [1:0] kind, logic [7:0] data, logic trunc);
			tld_result_t r;
			r.kind = kind;
			r.data = data;
			r.last = 1'b0;
			r.trunc = trunc;
			run.push_back(r);
		endfunction

		function void take_byte(logic [7:0] b);
			int i;
			run.delete();
			if (parse_mode == MODE_CMD) begin
				// The command code is consumed whatever its value.
				pending_cmd = b;
				parse_mode = (b >= BYTE_WILL && b <= BYTE_DONT) ? MODE_OPT : MODE_TEXT;
			end else if (parse_mode == MODE_OPT) begin
				if (b == BYTE_OPT_ECHO) begin
					if (pending_cmd == BYTE_DO)
						echo_on = 1'b1;
					else if (pending_cmd == BYTE_DONT)
						echo_on = 1'b0;
				end
				parse_mode = MODE_TEXT;
			end else begin
				parse_mode = MODE_TEXT;
				if (b == BYTE_IAC) begin
					parse_mode = MODE_CMD;
				end else if (b == BYTE_CR) begin
					if (echo_on) begin
						add(KIND_ECHO, BYTE_CR, 1'b0);
						add(KIND_ECHO, BYTE_LF, 1'b0);
					end
					for (i = 0; i < line_len; i++)
						add(KIND_CHAR, line_chars[i], 1'b0);
					add(KIND_END, 8'd0, overflow);
					line_len = 0;
					overflow = 1'b0;
				end else if (b == BYTE_BS || b == BYTE_DEL) begin
					if (line_len > 0) begin
						line_len--;
						if (echo_on) begin
							add(KIND_ECHO, b, 1'b0);
							add(KIND_ECHO, BYTE_SPACE, 1'b0);
							add(KIND_ECHO, b, 1'b0);
						end
					end
				end else if (b >= BYTE_SPACE && b <= BYTE_PRINT_HI) begin
					if (line_len < LINE_DEPTH) begin
						line_chars[line_len] = b;
						line_len++;
						if (echo_on)
							add(KIND_ECHO, b, 1'b0);
					end else begin
						overflow = 1'b1;
					end
				end
			end
			if (run.size() > 0)
				run[run.size() - 1].last = 1'b1;
			foreach (run[k])
				due_results.push_back(run[k]);
		endfunction

		task report(string msg);
			if (errors < MAX_PRINTED)
				$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_result(logic [1:0] kind, logic [7:0] data, logic last, logic trunc);
			tld_result_t want;
			if (due_results.size() == 0) begin
				report($sformatf("unexpected result kind %0d data 0x%02h last %0b trunc %0b",
					kind, data, last, trunc));
			end else begin
				want = due_results.pop_front();
				if (want.kind !== kind || want.data !== data || want.last !== last ||
						want.trunc !== trunc)
					report($sformatf({"got kind %0d data 0x%02h last %0b trunc %0b, ",
						"wanted %0d 0x%02h %0b %0b"},
						kind, data, last, trunc, want.kind, want.data, want.last,
						want.trunc));
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic       run_last;
	logic       line_truncated;

	line_scoreboard sb;
	int  cycles = 0;
	int  sent = 0;
	int  tight_left = 0;
	bit  hold_request = 1'b0;
	bit  hold_active = 1'b0;

	telnet_line_discipline_core #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_kind       (out_kind),
		.out_byte       (out_byte),
		.run_last       (run_last),
		.line_truncated (line_truncated)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("telnet_line_discipline_core test failed");
			$finish;
		end
	end

	// Both handshakes are sampled at the edge, before the driven values move.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.take_byte(rx_byte);
			if (out_valid && out_ready)
				sb.check_result(out_kind, out_byte, run_last, line_truncated);
		end
	end

	// Mostly zero, sometimes a few cycles, rarely a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Result side: bursts of ready with random stalls, and a long hold-off
	// when the sender asks for one.
	initial begin
		int n;
		int g;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				hold_active = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
			end else begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
				out_ready <= 1'b1;
				repeat (n) @(posedge clk);
				g = pick_gap();
				if (g > 0) begin
					out_ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
		end
	end

	// Offers one item and returns at the edge where it is taken, with
	// valid still high so a following item can go out back to back.
	task automatic send_item(input logic [7:0] b);
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
	endtask

	task automatic feed(input logic [7:0] b);
		int g;
		send_item(b);
		if (tight_left > 0) begin
			tight_left--;
		end else if ($urandom_range(0, 19) == 0) begin
			tight_left = $urandom_range(20, 60);
		end else begin
			g = pick_gap();
			if (g > 0) begin
				in_valid <= 1'b0;
				rx_byte <= 8'($urandom);
				repeat (g) @(posedge clk);
			end
		end
	endtask

	// The extra edge lets the monitor note the last accepted item first.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic send_line();
		int r;
		int len;
		int i;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 80)
			len = $urandom_range(0, 10);
		else if (r < 95)
			len = $urandom_range(11, 31);
		else
			len = $urandom_range(32, 45);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0)
				c = $urandom_range(0, 1) ? BYTE_BS : BYTE_DEL;
			else
				c = 8'($urandom_range(32, 126));
			feed(c);
		end
		feed(BYTE_CR);
		sent += len + 1;
	endtask

	task automatic negotiate();
		int r;
		logic [7:0] cmd;
		logic [7:0] opt;
		r = $urandom_range(0, 99);
		if (r < 40)
			cmd = BYTE_DO;
		else if (r < 60)
			cmd = BYTE_DONT;
		else if (r < 75)
			cmd = BYTE_WILL;
		else if (r < 90)
			cmd = BYTE_WONT;
		else
			cmd = 8'($urandom_range(0, 255));
		opt = ($urandom_range(0, 3) != 0) ? BYTE_OPT_ECHO : 8'($urandom_range(0, 255));
		feed(BYTE_IAC);
		feed(cmd);
		sent += 2;
		if (cmd >= BYTE_WILL && cmd <= BYTE_DONT) begin
			feed(opt);
			sent++;
		end
	endtask

	// Fill the block while the result side is held off, then let it drain.
	task automatic stall_burst();
		int i;
		logic [7:0] c;
		wait_drained();
		feed(BYTE_IAC);
		feed(BYTE_DO);
		feed(BYTE_OPT_ECHO);
		wait_drained();
		hold_request = 1'b1;
		while (!hold_active)
			@(posedge clk);
		for (i = 0; i < 30; i++) begin
			c = 8'($urandom_range(32, 126));
			send_item(c);
		end
		feed(BYTE_CR);
		sent += 34;
	endtask

	initial begin
		int r;
		bit burst_done;
		logic [7:0] c;
		sb = new();
		burst_done = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, echo off after reset: text extremes, erase, a line.
		feed(8'd65);
		feed(BYTE_SPACE);
		feed(BYTE_PRINT_HI);
		feed(BYTE_BS);
		feed(BYTE_CR);
		// Erase on an empty line and bytes outside text are silent.
		feed(BYTE_DEL);
		feed(8'd0);
		feed(8'd31);
		feed(8'd200);
		// DO ECHO, then echoed text, both erase codes and a CR with echo.
		feed(BYTE_IAC);
		feed(BYTE_DO);
		feed(BYTE_OPT_ECHO);
		feed(8'd122);
		feed(BYTE_DEL);
		feed(BYTE_BS);
		feed(8'd113);
		feed(BYTE_BS);
		feed(8'd107);
		feed(BYTE_CR);
		// CR and IAC inside a command are consumed as command bytes.
		feed(BYTE_IAC);
		feed(BYTE_CR);
		feed(BYTE_IAC);
		feed(BYTE_WILL);
		feed(BYTE_CR);
		feed(BYTE_IAC);
		feed(BYTE_IAC);
		feed(BYTE_IAC);
		feed(BYTE_WONT);
		feed(BYTE_IAC);
		feed(BYTE_CR);
		// DONT ECHO turns echo off again.
		feed(BYTE_IAC);
		feed(BYTE_DONT);
		feed(BYTE_OPT_ECHO);
		feed(BYTE_CR);
		wait_drained();

		// Random part: mostly whole lines and negotiations, some noise.
		while (sent < RANDOM_ITEMS) begin
			if (!burst_done && sent >= RANDOM_ITEMS / 2) begin
				stall_burst();
				burst_done = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 55) begin
				send_line();
			end else if (r < 78) begin
				negotiate();
			end else if (r < 86) begin
				// A broken command: IAC followed by any byte.
				feed(BYTE_IAC);
				c = 8'($urandom_range(0, 255));
				feed(c);
			end else if (r < 90) begin
				wait_drained();
			end else begin
				c = 8'($urandom_range(0, 255));
				feed(c);
			end
		end

		wait_drained();
		repeat (DRAIN_TAIL) @(posedge clk);
		while (sb.pending() != 0) begin
			c = sb.due_results[0].data;
			sb.report($sformatf("expected result kind %0d data 0x%02h never arrived",
				sb.due_results[0].kind, c));
			void'(sb.due_results.pop_front());
		end
		if (sb.errors == 0)
			$display("telnet_line_discipline_core test passed");
		else
			$display("telnet_line_discipline_core test failed");
		$finish;
	end

endmodule

`default_nettype wire
